// ----- hw/rtl/pttl_pkg.sv -----
package pttl_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int ADDR_BITS_DEF   = 16;

	localparam int PS_W        = 16;
	localparam int CNT_CFG_W   = 5;
	localparam int FRAME_OUT_W = 4;
	localparam int PHYS_W      = 20;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [PS_W-1:0]      PS_RESET      = PS_W'(256);
	localparam logic [CNT_CFG_W-1:0] ENTRIES_RESET = CNT_CFG_W'(16);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAGE_SIZE = 2'd0,
		REG_ENTRIES   = 2'd1,
		REG_POLICY    = 2'd2
	} cfg_reg_t;

	localparam logic POLICY_LRU  = 1'b0;
	localparam logic POLICY_FIFO = 1'b1;

	typedef struct packed {
		logic                   fault;
		logic [FRAME_OUT_W-1:0] frame;
		logic [PHYS_W-1:0]      phys;
	} res_t;

endpackage

// ----- hw/rtl/page_table_translate_lru_fifo_core.sv -----
// channel    | ports                                           | transfer
// -----------+-------------------------------------------------+------------------------
// request    | push, full, virtual_address                     | push && !full
// result     | empty, pop, fault, frame, physical_address      | pop && !empty
// config     | cfg_valid, cfg_ready, cfg_index, cfg_data       | cfg_valid && cfg_ready
//
// front divider takes one request at a time, one quotient bit a cycle while it divides
// table walk reads and compares one slot at a time, then on an eviction or an LRU hit
// shifts the entries down one by one, a read and a write for each; one request at a time
// a two-entry queue sits between divider and table, another on the result side
// reset empties the table and the queues and loads the register defaults
// a full result queue stalls the table walk, which backs up into the divider
module page_table_translate_lru_fifo_core #(
	parameter int MAX_ENTRIES = pttl_pkg::MAX_ENTRIES_DEF,
	parameter int ADDR_BITS   = pttl_pkg::ADDR_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [ADDR_BITS-1:0]              virtual_address,
	output logic                              empty,
	input  logic                              pop,
	output logic                              fault,
	output logic [pttl_pkg::FRAME_OUT_W-1:0]  frame,
	output logic [pttl_pkg::PHYS_W-1:0]       physical_address,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pttl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pttl_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int PS_W  = pttl_pkg::PS_W;
	localparam int CW    = $clog2(MAX_ENTRIES + 1);
	localparam int MID_W = ADDR_BITS + 2 * PS_W;
	localparam int RES_W = $bits(pttl_pkg::res_t);

	logic [PS_W-1:0]                page_size_q;
	logic [pttl_pkg::CNT_CFG_W-1:0] entries_q;
	logic                           policy_q;
	logic [CW-1:0]                  slots;

	logic             mid_push;
	logic [MID_W-1:0] mid_wdata;
	logic             mid_full;
	logic             mid_pop;
	logic [MID_W-1:0] mid_rdata;
	logic             mid_empty;

	logic             res_push;
	pttl_pkg::res_t   res_wdata;
	logic             res_full;
	logic [RES_W-1:0] res_rdata;
	pttl_pkg::res_t   res_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q <= pttl_pkg::PS_RESET;
			entries_q   <= pttl_pkg::ENTRIES_RESET;
			policy_q    <= pttl_pkg::POLICY_LRU;
		end else if (cfg_valid) begin
			case (cfg_index)
				pttl_pkg::REG_PAGE_SIZE: page_size_q <= cfg_data[PS_W-1:0];
				pttl_pkg::REG_ENTRIES:   entries_q   <= cfg_data[pttl_pkg::CNT_CFG_W-1:0];
				pttl_pkg::REG_POLICY:    policy_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// zero slots behaves as one, more than the table holds saturates
	always_comb begin
		if (entries_q == '0) begin
			slots = CW'(1);
		end else if (32'(entries_q) > MAX_ENTRIES) begin
			slots = CW'(MAX_ENTRIES);
		end else begin
			slots = CW'(entries_q);
		end
	end

	pttl_front #(
		.ADDR_BITS(ADDR_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.virtual_address(virtual_address),
		.full           (full),
		.page_size      (page_size_q),
		.out_push       (mid_push),
		.out_data       (mid_wdata),
		.out_full       (mid_full)
	);

	pttl_queue #(
		.W(MID_W)
	) u_mid_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mid_push),
		.wdata (mid_wdata),
		.full  (mid_full),
		.pop   (mid_pop),
		.rdata (mid_rdata),
		.empty (mid_empty)
	);

	pttl_table #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.ADDR_BITS  (ADDR_BITS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_empty(mid_empty),
		.in_data (mid_rdata),
		.in_pop  (mid_pop),
		.slots   (slots),
		.policy  (policy_q),
		.out_push(res_push),
		.out_res (res_wdata),
		.out_full(res_full)
	);

	pttl_queue #(
		.W(RES_W)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_wdata),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_rdata),
		.empty (empty)
	);

	assign res_head         = res_rdata;
	assign fault            = res_head.fault;
	assign frame            = res_head.frame;
	assign physical_address = res_head.phys;

endmodule

// ----- hw/rtl/pttl_queue.sv -----
module pttl_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int PW = (pttl_pkg::QUEUE_DEPTH > 1) ? $clog2(pttl_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(pttl_pkg::QUEUE_DEPTH + 1);

	logic [W-1:0]  data_q [pttl_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(pttl_pkg::QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = data_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			data_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(pttl_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(pttl_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/pttl_front.sv -----
module pttl_front #(
	parameter int ADDR_BITS = pttl_pkg::ADDR_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	input  logic [ADDR_BITS-1:0]                   virtual_address,
	output logic                                   full,
	input  logic [pttl_pkg::PS_W-1:0]              page_size,
	output logic                                   out_push,
	output logic [ADDR_BITS+2*pttl_pkg::PS_W-1:0]  out_data,
	input  logic                                   out_full
);

	localparam int PS_W = pttl_pkg::PS_W;
	localparam int NW   = $clog2(ADDR_BITS + 1);

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} fstate_t;

	fstate_t              state_q;
	logic [NW-1:0]        cnt_q;
	logic [ADDR_BITS-1:0] dvd_q;
	logic [PS_W-1:0]      rem_q;
	logic [PS_W-1:0]      ps_q;
	logic [PS_W:0]        trial;
	logic [PS_W:0]        diff;
	logic                 ge;

	// restoring division, one quotient bit a cycle shifted into the dividend
	assign trial = {rem_q, dvd_q[ADDR_BITS-1]};
	assign diff  = trial - {1'b0, ps_q};
	assign ge    = (trial >= {1'b0, ps_q});

	assign full     = (state_q != F_IDLE);
	assign out_push = (state_q == F_PUSH);
	assign out_data = {dvd_q, rem_q, ps_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (push) begin
						dvd_q   <= virtual_address;
						rem_q   <= '0;
						ps_q    <= (page_size == '0) ? PS_W'(1) : page_size;
						cnt_q   <= NW'(ADDR_BITS);
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					dvd_q <= {dvd_q[ADDR_BITS-2:0], ge};
					rem_q <= ge ? diff[PS_W-1:0] : trial[PS_W-1:0];
					cnt_q <= cnt_q - NW'(1);
					if (cnt_q == NW'(1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!out_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/pttl_table.sv -----
module pttl_table #(
	parameter int MAX_ENTRIES = pttl_pkg::MAX_ENTRIES_DEF,
	parameter int ADDR_BITS   = pttl_pkg::ADDR_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_empty,
	input  logic [ADDR_BITS+2*pttl_pkg::PS_W-1:0] in_data,
	output logic                                  in_pop,
	input  logic [$clog2(MAX_ENTRIES+1)-1:0]      slots,
	input  logic                                  policy,
	output logic                                  out_push,
	output pttl_pkg::res_t                        out_res,
	input  logic                                  out_full
);

	localparam int PS_W = pttl_pkg::PS_W;
	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int FW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int EW   = ADDR_BITS + FW;
	localparam int MW   = FW + PS_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CMP,
		ST_MUL,
		ST_EVICT,
		ST_SH_RD,
		ST_SH_WR,
		ST_DONE
	} bstate_t;

	bstate_t              state_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        vc_q;
	logic [ADDR_BITS-1:0] page_q;
	logic [PS_W-1:0]      off_q;
	logic [PS_W-1:0]      ps_q;
	logic [FW-1:0]        keep_q;
	pttl_pkg::res_t       res_q;

	// entry = {page, frame}
	logic [EW-1:0] mem [MAX_ENTRIES];
	logic [EW-1:0] rd_q;
	logic [FW-1:0] rd_addr;
	logic          wr_en;
	logic [FW-1:0] wr_addr;
	logic [EW-1:0] wr_data;

	logic [CW-1:0]        lim;
	logic [CW:0]          nxt;
	logic [ADDR_BITS-1:0] rd_page;
	logic [FW-1:0]        rd_frame;
	logic [MW-1:0]        phys_full;

	// valid entries always form a prefix, so the fill count stands for the valid bits
	assign lim      = (vc_q < slots) ? vc_q : slots;
	assign nxt      = (CW+1)'(idx_q) + (CW+1)'(1);
	assign rd_page  = rd_q[EW-1:FW];
	assign rd_frame = rd_q[FW-1:0];
	assign phys_full = MW'(keep_q) * MW'(ps_q) + MW'(off_q);

	assign in_pop   = (state_q == ST_IDLE) && !in_empty;
	assign out_push = (state_q == ST_DONE) && !out_full;
	assign out_res  = res_q;

	always_comb begin
		rd_addr = idx_q[FW-1:0];
		wr_en   = 1'b0;
		wr_addr = idx_q[FW-1:0];
		wr_data = {page_q, keep_q};
		case (state_q)
			ST_CHECK: begin
				if (idx_q == slots) begin
					rd_addr = '0;
				end else if (idx_q >= vc_q) begin
					wr_en   = 1'b1;
					wr_data = {page_q, idx_q[FW-1:0]};
				end
			end
			ST_SH_RD: begin
				if (nxt < (CW+1)'(lim)) begin
					rd_addr = FW'(nxt);
				end else begin
					wr_en = 1'b1;
				end
			end
			ST_SH_WR: begin
				wr_en   = 1'b1;
				wr_data = rd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vc_q    <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!in_empty) begin
						page_q  <= in_data[ADDR_BITS+2*PS_W-1:2*PS_W];
						off_q   <= in_data[2*PS_W-1:PS_W];
						ps_q    <= in_data[PS_W-1:0];
						idx_q   <= '0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (idx_q == slots) begin
						state_q <= ST_EVICT;
					end else if (idx_q >= vc_q) begin
						// empty slot: frame is the slot index
						vc_q    <= vc_q + CW'(1);
						res_q   <= '{fault: 1'b1,
						             frame: pttl_pkg::FRAME_OUT_W'(idx_q),
						             phys: '0};
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (rd_page == page_q) begin
						keep_q  <= rd_frame;
						state_q <= ST_MUL;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= ST_CHECK;
					end
				end
				ST_MUL: begin
					res_q   <= '{fault: 1'b0,
					             frame: pttl_pkg::FRAME_OUT_W'(keep_q),
					             phys: pttl_pkg::PHYS_W'(phys_full)};
					state_q <= (policy == pttl_pkg::POLICY_LRU) ? ST_SH_RD : ST_DONE;
				end
				ST_EVICT: begin
					// oldest entry leaves, its frame goes to the new page at the tail
					keep_q  <= rd_frame;
					res_q   <= '{fault: 1'b1,
					             frame: pttl_pkg::FRAME_OUT_W'(rd_frame),
					             phys: '0};
					idx_q   <= '0;
					state_q <= ST_SH_RD;
				end
				ST_SH_RD: begin
					state_q <= (nxt < (CW+1)'(lim)) ? ST_SH_WR : ST_DONE;
				end
				ST_SH_WR: begin
					idx_q   <= idx_q + CW'(1);
					state_q <= ST_SH_RD;
				end
				ST_DONE: begin
					if (!out_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- test/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pttl_pkg::*;

	localparam int SLOTS        = MAX_ENTRIES_DEF;
	localparam int RANDOM_ITEMS = 1600;
	localparam int QUIET_FROM   = 700;
	localparam int QUIET_TO     = 1000;
	localparam int HOLD_CYCLES  = 500;
	localparam int STALL_LIMIT  = 6000;
	localparam int SETTLE       = 120;
	localparam int MAX_PRINTS   = 40;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   reg_idx;
		logic [CFG_DATA_W-1:0]  value;   // address for a request, data for a write
		logic                   typed;
		res_t                   want;
	} stim_row_t;

	localparam res_t NO_RES = '0;

	localparam int DIRECTED_ROWS = 30;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{ROW_REQ, REG_PAGE_SIZE, 16'h0000, 1'b1, '{1'b1, 4'd0, 20'h00000}},
		'{ROW_REQ, REG_PAGE_SIZE, 16'hFFFF, 1'b1, '{1'b1, 4'd1, 20'h00000}},
		'{ROW_REQ, REG_PAGE_SIZE, 16'h00FF, 1'b1, '{1'b0, 4'd0, 20'h000FF}},
		'{ROW_REQ, REG_PAGE_SIZE, 16'hFF00, 1'b1, '{1'b0, 4'd1, 20'h00100}},
		'{ROW_CFG, REG_POLICY,    16'h0001, 1'b0, NO_RES},
		'{ROW_REQ, REG_PAGE_SIZE, 16'h0080, 1'b1, '{1'b0, 4'd0, 20'h00080}},
		'{ROW_REQ, REG_PAGE_SIZE, 16'hFF7F, 1'b1, '{1'b0, 4'd1, 20'h0017F}},
		'{ROW_CFG, REG_ENTRIES,   16'h0002, 1'b0, NO_RES},
		'{ROW_REQ, REG_PAGE_SIZE, 16'h1234, 1'b0, NO_RES},
		'{ROW_REQ, REG_PAGE_SIZE, 16'h0010, 1'b0, NO_RES},
		'{ROW_CFG, REG_ENTRIES,   16'h0000, 1'b0, NO_RES},
		'{ROW_REQ, REG_PAGE_SIZE, 16'h0000, 1'b0, NO_RES},
		'{ROW_CFG, REG_ENTRIES,   16'h001F, 1'b0, NO_RES},
		'{ROW_REQ, REG_PAGE_SIZE, 16'h0020, 1'b0, NO_RES},
		'{ROW_REQ, REG_PAGE_SIZE, 16'hABCD, 1'b0, NO_RES},
		'{ROW_CFG, REG_PAGE_SIZE, 16'h0000, 1'b0, NO_RES},
		'{ROW_REQ, REG_PAGE_SIZE, 16'h0003, 1'b0, NO_RES},
		'{ROW_REQ, REG_PAGE_SIZE, 16'h0000, 1'b0, NO_RES},
		'{ROW_CFG, REG_PAGE_SIZE, 16'hFFFF, 1'b0, NO_RES},
		'{ROW_REQ, REG_PAGE_SIZE, 16'hFFFF, 1'b0, NO_RES},
		'{ROW_REQ, REG_PAGE_SIZE, 16'hFFFE, 1'b0, NO_RES},
		'{ROW_CFG, REG_NONE,      16'hFFFF, 1'b0, NO_RES},
		'{ROW_REQ, REG_PAGE_SIZE, 16'h7FFF, 1'b0, NO_RES},
		'{ROW_CFG, REG_POLICY,    16'hFFFE, 1'b0, NO_RES},
		'{ROW_CFG, REG_PAGE_SIZE, 16'h0001, 1'b0, NO_RES},
		'{ROW_REQ, REG_PAGE_SIZE, 16'h5555, 1'b0, NO_RES},
		'{ROW_REQ, REG_PAGE_SIZE, 16'hAAAA, 1'b0, NO_RES},
		'{ROW_REQ, REG_PAGE_SIZE, 16'h5555, 1'b0, NO_RES},
		'{ROW_CFG, REG_ENTRIES,   16'hFFF0, 1'b0, NO_RES},
		'{ROW_CFG, REG_PAGE_SIZE, 16'h0100, 1'b0, NO_RES}
	};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   push = 1'b0;
	logic                   full;
	logic [15:0]            virtual_address = '0;
	logic                   empty;
	logic                   pop = 1'b0;
	logic                   fault;
	logic [FRAME_OUT_W-1:0] frame;
	logic [PHYS_W-1:0]      physical_address;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = REG_PAGE_SIZE;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// translation table mirror and register copies
	logic                   slot_valid [SLOTS];
	logic [15:0]            slot_page  [SLOTS];
	logic [FRAME_OUT_W-1:0] slot_frame [SLOTS];
	logic [PS_W-1:0]        cfg_page_size = PS_RESET;
	logic [CNT_CFG_W-1:0]   cfg_entries = ENTRIES_RESET;
	logic                   cfg_policy = POLICY_LRU;

	res_t        pending_translations [$];
	int unsigned errors = 0;
	int unsigned items_sent = 0;
	int unsigned results_got = 0;
	int unsigned faults_predicted = 0;
	int unsigned hits_predicted = 0;
	int unsigned reg_writes = 0;
	logic        hold_results = 1'b0;
	logic        hold_done = 1'b0;

	page_table_translate_lru_fifo_core uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.virtual_address  (virtual_address),
		.empty            (empty),
		.pop              (pop),
		.fault            (fault),
		.frame            (frame),
		.physical_address (physical_address),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic res_t translate_address(input logic [15:0] va);
		int unsigned ps, pg, off, n, idx, i;
		logic [FRAME_OUT_W-1:0] hit_frame;
		res_t r;
		ps = (cfg_page_size == 0) ? 1 : cfg_page_size;
		pg = va / ps;
		off = va % ps;
		n = (cfg_entries == 0) ? 1 : ((cfg_entries > SLOTS) ? SLOTS : cfg_entries);
		idx = 0;
		while (idx < n && slot_valid[idx] && slot_page[idx] != pg)
			idx++;
		r = '0;
		if (idx == n) begin
			// table full, the oldest slot gives up its frame
			hit_frame = slot_frame[0];
			for (i = 0; i + 1 < n; i++) begin
				slot_page[i] = slot_page[i+1];
				slot_frame[i] = slot_frame[i+1];
			end
			slot_page[n-1] = pg[15:0];
			slot_frame[n-1] = hit_frame;
			slot_valid[n-1] = 1'b1;
			r.fault = 1'b1;
			r.frame = hit_frame;
			faults_predicted++;
		end else if (!slot_valid[idx]) begin
			slot_valid[idx] = 1'b1;
			slot_page[idx] = pg[15:0];
			slot_frame[idx] = idx[FRAME_OUT_W-1:0];
			r.fault = 1'b1;
			r.frame = idx[FRAME_OUT_W-1:0];
			faults_predicted++;
		end else begin
			hit_frame = slot_frame[idx];
			if (cfg_policy == POLICY_LRU) begin
				i = idx;
				while (i + 1 < n && slot_valid[i+1]) begin
					slot_page[i] = slot_page[i+1];
					slot_frame[i] = slot_frame[i+1];
					i++;
				end
				slot_page[i] = pg[15:0];
				slot_frame[i] = hit_frame;
			end
			r.fault = 1'b0;
			r.frame = hit_frame;
			r.phys = PHYS_W'(hit_frame * ps + off);
			hits_predicted++;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("mismatch on result %0d: %s got 0x%0h want 0x%0h", results_got, what,
				got, want);
	endtask

	task automatic send_request(input logic [15:0] va, input logic typed, input res_t want);
		res_t predicted;
		while ($urandom_range(99) < 34 && !(items_sent >= QUIET_FROM && items_sent < QUIET_TO))
		begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		virtual_address <= va;
		do @(posedge clk); while (full);
		predicted = translate_address(va);
		pending_translations.push_back(typed ? want : predicted);
		items_sent++;
	endtask

	// leaves cfg_valid high so back-to-back writes follow without a gap
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PAGE_SIZE: cfg_page_size = data;
			REG_ENTRIES: cfg_entries = data[CNT_CFG_W-1:0];
			REG_POLICY: cfg_policy = data[0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (pending_translations.size() != 0)
			@(posedge clk);
	endtask

	// result side
	initial begin
		res_t want;
		wait (arst_n);
		forever begin
			if (hold_results && !hold_done) begin
				// long hold-off so the request side backs up and stalls
				pop <= 1'b0;
				hold_done = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			pop <= !($urandom_range(99) < 34 &&
				!(results_got >= QUIET_FROM && results_got < QUIET_TO));
			@(posedge clk);
			if (pop && !empty) begin
				if (pending_translations.size() == 0) begin
					report_mismatch("result with no request pending", 0, 0);
				end else begin
					want = pending_translations.pop_front();
					if (fault !== want.fault)
						report_mismatch("fault", fault, want.fault);
					if (frame !== want.frame)
						report_mismatch("frame", frame, want.frame);
					if (physical_address !== want.phys)
						report_mismatch("physical_address", physical_address, want.phys);
				end
				results_got++;
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("page_table_translate_lru_fifo_core test failed");
		$finish;
	end

	initial begin
		int unsigned row, phase, random_sent, n_items, k, ps_eff, max_page, pick;
		logic [CFG_DATA_W-1:0] data;
		int unsigned hot_pages [$];
		for (row = 0; row < SLOTS; row++)
			slot_valid[row] = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < DIRECTED_ROWS; row++) begin
			if (DIRECTED[row].kind == ROW_CFG) begin
				wait_drained();
				write_reg(DIRECTED[row].reg_idx, DIRECTED[row].value);
			end else begin
				cfg_valid <= 1'b0;
				send_request(DIRECTED[row].value, DIRECTED[row].typed, DIRECTED[row].want);
			end
		end

		phase = 0;
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			// each setting change waits for the block to go idle
			wait_drained();
			case ($urandom_range(7))
				0: data = 16'h0000;
				1: data = 16'h0001;
				2: data = 16'hFFFF;
				3: data = 16'h0100;
				4, 5: data = CFG_DATA_W'($urandom_range(64, 2));
				6: data = CFG_DATA_W'($urandom_range(4096, 65));
				default: data = CFG_DATA_W'($urandom);
			endcase
			write_reg(REG_PAGE_SIZE, data);
			data = CFG_DATA_W'($urandom);
			case ($urandom_range(5))
				0: data[CNT_CFG_W-1:0] = 5'd0;
				1: data[CNT_CFG_W-1:0] = 5'd1;
				2: data[CNT_CFG_W-1:0] = 5'd16;
				3: data[CNT_CFG_W-1:0] = CNT_CFG_W'($urandom_range(31, 17));
				default: data[CNT_CFG_W-1:0] = CNT_CFG_W'($urandom_range(15, 2));
			endcase
			write_reg(REG_ENTRIES, data);
			write_reg(REG_POLICY, CFG_DATA_W'($urandom));
			if ($urandom_range(4) == 0)
				write_reg(REG_NONE, CFG_DATA_W'($urandom));
			cfg_valid <= 1'b0;

			if (phase == 2)
				hold_results = 1'b1;

			// a small set of pages gives hits, refills and evictions
			ps_eff = (cfg_page_size == 0) ? 1 : cfg_page_size;
			max_page = 65535 / ps_eff;
			hot_pages.delete();
			n_items = $urandom_range(24, 1);
			for (k = 0; k < n_items; k++)
				hot_pages.push_back($urandom_range(max_page));

			n_items = $urandom_range(120, 40);
			for (k = 0; k < n_items && random_sent < RANDOM_ITEMS; k++) begin
				if ($urandom_range(99) < 80) begin
					pick = hot_pages[$urandom_range(hot_pages.size() - 1)] * ps_eff +
						$urandom_range(ps_eff - 1);
					if (pick > 65535)
						pick = 65535;
				end else begin
					pick = $urandom_range(65535);
				end
				send_request(pick[15:0], 1'b0, NO_RES);
				random_sent++;
			end
			phase++;
		end

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		$display("%0d translations checked (%0d faults, %0d hits), %0d register writes in %0d phases",
			results_got, faults_predicted, hits_predicted, reg_writes, phase);
		$display("both policies, page sizes down to zero and slot counts 0 to 31 exercised");
		if (errors == 0 && pending_translations.size() == 0)
			$display("page_table_translate_lru_fifo_core test passed");
		else
			$display("page_table_translate_lru_fifo_core test failed");
		$finish;
	end

endmodule
